[rtl/core/telecine_field_metric_decider_top_defines.svh]
// ============================================================================
// Assertion macros for the telecine field metric decider
// Clocked on i_clk, disabled while i_rst_n is low.
// ============================================================================
`ifndef TELECINE_FIELD_METRIC_DECIDER_TOP_DEFINES_SVH
`define TELECINE_FIELD_METRIC_DECIDER_TOP_DEFINES_SVH

// Check a condition at every edge
`define TFMD_ASSERT_NOW(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check a consequence in the same cycle
`define TFMD_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the next cycle
`define TFMD_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tfmd_pkg.sv]
// ============================================================================
// tfmd_pkg
// Types and constants shared by the telecine field metric decider.
// ============================================================================
package tfmd_pkg;

    // Geometry of one row beat
    localparam int LANES     = 8;
    localparam int PIX_W     = 8;
    localparam int ROW_IDX_W = 3;
    localparam logic [ROW_IDX_W-1:0] ROW_LAST = 3'd7;

    // Arithmetic widths
    localparam int COL_W = 11;   // signed column sum over four row pairs
    localparam int MAG_W = 10;   // magnitude of a column sum
    localparam int ROW_W = 11;   // sum of eight absolute differences
    localparam int REL_W = 13;   // block sums and frame maxima
    localparam int CFG_W = 14;
    localparam logic [REL_W-1:0] REL_LIMIT = 13'd8160;

    // Configuration registers
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam logic [1:0] REG_COMBING   = 2'd0;
    localparam logic [1:0] REG_TEMPORAL  = 2'd1;
    localparam logic [1:0] REG_LOW_NOISE = 2'd2;
    localparam logic [CFG_W-1:0] COMBING_RST   = 14'd1200;
    localparam logic [CFG_W-1:0] TEMPORAL_RST  = 14'd3600;
    localparam logic [CFG_W-1:0] LOW_NOISE_RST = 14'd900;

    typedef enum logic [1:0] {
        DEC_SHOW,
        DEC_DROP,
        DEC_NEXT,
        DEC_MERGE
    } t_decision;

    typedef struct packed {
        logic [63:0] old_pixels;
        logic [63:0] new_pixels;
        logic        frame_last;
    } t_in_item;

    typedef struct packed {
        t_decision        decision;
        logic [REL_W-1:0] rel_even;
        logic [REL_W-1:0] rel_odd;
        logic [REL_W-1:0] rel_spatial;
        logic [REL_W-1:0] rel_past;
        logic [REL_W-1:0] rel_temporal;
        logic [REL_W-1:0] rel_diff;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] combing_threshold;
        logic [CFG_W-1:0] temporal_limit;
        logic [CFG_W-1:0] low_noise_threshold;
    } t_cfg;

    // Column magnitudes of one finished block, one set per lane
    typedef struct packed {
        logic [MAG_W-1:0] sp;
        logic [MAG_W-1:0] pa;
        logic [MAG_W-1:0] tm;
    } t_col_mag;

    // Finished block handed from the row stage to the merge stages
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [REL_W-1:0] even;
        logic [REL_W-1:0] odd;
    } t_blk_sums;

    typedef struct packed {
        logic [REL_W-1:0] re;
        logic [REL_W-1:0] ro;
        logic [REL_W-1:0] rs;
        logic [REL_W-1:0] rp;
        logic [REL_W-1:0] rt;
        logic [REL_W-1:0] rd;
    } t_rel_max;

    typedef struct packed {
        logic [REL_W-1:0] pe;
        logic [REL_W-1:0] po;
        logic [REL_W-1:0] ps;
        logic [REL_W-1:0] pd;
    } t_prev_max;

    typedef struct packed {
        logic hold;   // output holds a stalled result
        logic busy;   // a block sits in the merge stages
    } t_tail_status;

endpackage

[rtl/core/tfmd_lane.sv]
// ============================================================================
// tfmd_lane
// One pixel column: absolute difference and the three signed column sums.
// ============================================================================
module tfmd_lane (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic                      i_odd,
    input  logic                      i_row_last,
    input  logic [tfmd_pkg::PIX_W-1:0] i_old,
    input  logic [tfmd_pkg::PIX_W-1:0] i_new,
    output logic [tfmd_pkg::PIX_W-1:0] o_abs_diff,
    output tfmd_pkg::t_col_mag        o_mag
);
    import tfmd_pkg::*;

    logic signed [COL_W-1:0] r_sp, r_pa, r_tm;
    logic signed [COL_W-1:0] n_sp, n_pa, n_tm;
    logic signed [COL_W-1:0] w_old, w_new;
    logic        [PIX_W:0]   w_diff;
    t_col_mag                r_mag;

    function automatic logic [MAG_W-1:0] mag(input logic signed [COL_W-1:0] v);
        logic signed [COL_W-1:0] a;
        begin
            a = (v < 0) ? -v : v;
            return a[MAG_W-1:0];
        end
    endfunction

    assign w_old = $signed({{(COL_W-PIX_W){1'b0}}, i_old});
    assign w_new = $signed({{(COL_W-PIX_W){1'b0}}, i_new});

    // Absolute pixel difference
    assign w_diff     = {1'b0, i_new} - {1'b0, i_old};
    assign o_abs_diff = w_diff[PIX_W] ? PIX_W'(-w_diff) : w_diff[PIX_W-1:0];

    // Add odd rows, subtract even rows
    always_comb begin
        if (i_odd) begin
            n_sp = r_sp + w_new;
            n_pa = r_pa + w_old;
            n_tm = r_tm + w_old;
        end else begin
            n_sp = r_sp - w_new;
            n_pa = r_pa - w_old;
            n_tm = r_tm - w_new;
        end
    end

    // Accumulate, clear at the end of a block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
            r_pa <= '0;
            r_tm <= '0;
        end else if (i_load) begin
            if (i_row_last) begin
                r_sp <= '0;
                r_pa <= '0;
                r_tm <= '0;
            end else begin
                r_sp <= n_sp;
                r_pa <= n_pa;
                r_tm <= n_tm;
            end
        end
    end

    // Capture the column magnitudes of the finished block
    always_ff @(posedge i_clk) begin
        if (i_load && i_row_last) begin
            r_mag.sp <= mag(n_sp);
            r_mag.pa <= mag(n_pa);
            r_mag.tm <= mag(n_tm);
        end
    end

    assign o_mag = r_mag;

endmodule

[rtl/core/tfmd_rule.sv]
// ============================================================================
// tfmd_rule
// Pulldown rule: picks show, drop, next or merge from the frame maxima.
// ============================================================================
module tfmd_rule (
    input  tfmd_pkg::t_rel_max  i_cur,
    input  tfmd_pkg::t_prev_max i_prev,
    input  logic                i_drop_pending,
    input  tfmd_pkg::t_cfg      i_cfg,
    output tfmd_pkg::t_decision o_decision,
    output logic                o_drop_next
);
    import tfmd_pkg::*;

    localparam int CW = REL_W + 2;

    logic [CW-1:0] w_ro3, w_pe3, w_rp3, w_rt2, w_pd2;
    logic [CW-1:0] w_re, w_po, w_ps, w_rp, w_rs, w_rd, w_rt;
    logic [CW-1:0] w_comb, w_temp, w_noise;
    logic          w_next, w_q_comb, w_past_comb, w_cur_comb, w_merge_ok, w_merge_pat;

    // Widen everything to one compare width
    assign w_re    = CW'(i_cur.re);
    assign w_rs    = CW'(i_cur.rs);
    assign w_rp    = CW'(i_cur.rp);
    assign w_rt    = CW'(i_cur.rt);
    assign w_rd    = CW'(i_cur.rd);
    assign w_po    = CW'(i_prev.po);
    assign w_ps    = CW'(i_prev.ps);
    assign w_comb  = CW'(i_cfg.combing_threshold);
    assign w_temp  = CW'(i_cfg.temporal_limit);
    assign w_noise = CW'(i_cfg.low_noise_threshold);

    // Scaled terms, shift and add
    assign w_ro3 = CW'(i_cur.ro) + {CW'(i_cur.ro) << 1};
    assign w_pe3 = CW'(i_prev.pe) + {CW'(i_prev.pe) << 1};
    assign w_rp3 = w_rp + (w_rp << 1);
    assign w_rt2 = w_rt << 1;
    assign w_pd2 = CW'(i_prev.pd) << 1;

    assign w_next      = (w_ro3 < w_re) && (w_rs < w_rd);
    assign w_q_comb    = w_pe3 < w_po;
    assign w_past_comb = (w_pd2 < w_ps) && (w_ps > w_comb);
    assign w_cur_comb  = (w_rt2 < w_rp) && (w_rp > w_comb);
    assign w_merge_ok  = ((w_rt2 < w_rp3) && (w_rt < w_temp)) ||
                         (w_rt < w_noise) || (w_rd < w_noise);
    assign w_merge_pat = w_q_comb || (w_rt2 < w_rp);

    // Decide in priority order
    always_comb begin
        o_decision  = DEC_DROP;
        o_drop_next = 1'b0;
        if (i_drop_pending) begin
            o_decision = DEC_DROP;
        end else if (w_next) begin
            o_decision  = DEC_NEXT;
            o_drop_next = 1'b1;
        end else if (!(w_q_comb || w_past_comb || w_cur_comb)) begin
            o_decision = DEC_SHOW;
        end else if (w_merge_ok && w_merge_pat) begin
            o_decision  = DEC_MERGE;
            o_drop_next = 1'b1;
        end
    end

endmodule

[rtl/core/tfmd_merge.sv]
// ============================================================================
// tfmd_merge
// Merges lane magnitudes into block metrics, raises the frame maxima and
// runs the pulldown rule at frame end into the output register.
// ============================================================================
module tfmd_merge (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  tfmd_pkg::t_blk_sums                    i_blk,
    input  tfmd_pkg::t_col_mag [tfmd_pkg::LANES-1:0] i_mag,
    input  tfmd_pkg::t_cfg                         i_cfg,
    output tfmd_pkg::t_tail_status                 o_status,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output tfmd_pkg::t_out_item                    o_out_data
);
    import tfmd_pkg::*;

    localparam int DW = REL_W + 2;

    logic             w_hold, w_adv_c, w_fire;
    logic [REL_W-1:0] w_s, w_p, w_t;
    logic             r_c_valid, r_c_last;
    logic [REL_W-1:0] r_c_e, r_c_o, r_c_s, r_c_p, r_c_t;
    t_rel_max         r_cur, n_cur;
    t_prev_max        r_prev;
    logic             r_d_fin;
    logic             r_drop;
    t_decision        w_decision;
    logic             w_drop_next;
    logic             r_out_valid;
    t_out_item        r_out_data;

    function automatic logic signed [DW-1:0] sdiff(input logic [REL_W-1:0] a,
                                                   input logic [REL_W-1:0] b);
        return $signed({2'b00, a}) - $signed({2'b00, b});
    endfunction

    function automatic logic [REL_W-1:0] raise(input logic [REL_W-1:0] cur,
                                               input logic signed [DW-1:0] d);
        return (d > $signed({2'b00, cur})) ? d[REL_W-1:0] : cur;
    endfunction

    assign w_hold  = r_out_valid && i_out_stall;
    assign w_adv_c = r_c_valid && !w_hold;
    assign w_fire  = r_d_fin && !w_hold;

    // Sum the column magnitudes across lanes
    always_comb begin
        w_s = '0;
        w_p = '0;
        w_t = '0;
        for (int i = 0; i < LANES; i++) begin
            w_s = w_s + REL_W'(i_mag[i].sp);
            w_p = w_p + REL_W'(i_mag[i].pa);
            w_t = w_t + REL_W'(i_mag[i].tm);
        end
    end

    // Block metric stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (!w_hold) begin
            r_c_valid <= i_blk.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_hold && i_blk.valid) begin
            r_c_last <= i_blk.last;
            r_c_e    <= i_blk.even;
            r_c_o    <= i_blk.odd;
            r_c_s    <= w_s;
            r_c_p    <= w_p;
            r_c_t    <= w_t;
        end
    end

    // Raise the six relative maxima
    always_comb begin
        n_cur.re = raise(r_cur.re, sdiff(r_c_e, r_c_o));
        n_cur.ro = raise(r_cur.ro, sdiff(r_c_o, r_c_e));
        n_cur.rs = raise(r_cur.rs, sdiff(r_c_s, r_c_t));
        n_cur.rp = raise(r_cur.rp, sdiff(r_c_p, r_c_t));
        n_cur.rt = raise(r_cur.rt, sdiff(r_c_t, r_c_p));
        n_cur.rd = raise(r_cur.rd, sdiff(r_c_t, r_c_s));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_d_fin <= 1'b0;
        end else begin
            if (w_fire) begin
                r_cur <= '0;
            end else if (w_adv_c) begin
                r_cur <= n_cur;
            end
            if (!w_hold) begin
                r_d_fin <= r_c_valid && r_c_last;
            end
        end
    end

    tfmd_rule u_rule (
        .i_cur          (r_cur),
        .i_prev         (r_prev),
        .i_drop_pending (r_drop),
        .i_cfg          (i_cfg),
        .o_decision     (w_decision),
        .o_drop_next    (w_drop_next)
    );

    // Frame end: shift maxima to the previous copy, update drop-next flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_drop <= 1'b0;
        end else if (w_fire) begin
            r_prev.pe <= r_cur.re;
            r_prev.po <= r_cur.ro;
            r_prev.ps <= r_cur.rs;
            r_prev.pd <= r_cur.rd;
            r_drop    <= w_drop_next;
        end
    end

    // Output register, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data.decision     <= w_decision;
            r_out_data.rel_even     <= r_cur.re;
            r_out_data.rel_odd      <= r_cur.ro;
            r_out_data.rel_spatial  <= r_cur.rs;
            r_out_data.rel_past     <= r_cur.rp;
            r_out_data.rel_temporal <= r_cur.rt;
            r_out_data.rel_diff     <= r_cur.rd;
        end
    end

    assign o_status.hold = w_hold;
    assign o_status.busy = r_c_valid || r_d_fin;
    assign o_out_valid   = r_out_valid;
    assign o_out_data    = r_out_data;

endmodule

[rtl/core/telecine_field_metric_decider_top.sv]
// ============================================================================
// telecine_field_metric_decider_top
// Pulldown detector: eight column lanes work on one pixel row per beat,
// block metrics merge into frame maxima, the pulldown rule runs at frame end.
// ============================================================================
//
//  channel | direction | handshake           | beat
//  --------+-----------+---------------------+--------------------------------
//  in      | input     | i_in_valid/o_in_stall | one 8-pixel row, old and new
//  out     | output    | o_out_valid/i_out_stall | decision and six maxima
//  cfg     | input     | APB psel/penable    | three 14-bit threshold registers
//
//  One row beat is accepted every cycle unless the input stalls; the eight
//  lanes finish a row in the cycle it is accepted. After a frame's last row
//  its result passes the block register, metric stage and frame-end flag
//  into the output register. The input stalls only while a result waits
//  stalled at the output and a finished block is in the merge stages.
//  Reset is synchronous, active low, and clears the running sums and maxima.
//
module telecine_field_metric_decider_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  tfmd_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output tfmd_pkg::t_out_item                o_out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tfmd_pkg::APB_AW-1:0]        paddr,
    input  logic [tfmd_pkg::APB_DW-1:0]        pwdata,
    output logic [tfmd_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import tfmd_pkg::*;

    t_cfg                  r_cfg;
    logic [ROW_IDX_W-1:0]  r_row;
    logic                  w_accept, w_odd, w_row_last, w_tail_busy;
    logic [PIX_W-1:0]      w_abs [LANES];
    t_col_mag [LANES-1:0]  w_mag;
    logic [ROW_W-1:0]      w_row_sum;
    logic [REL_W-1:0]      r_even, r_odd;
    t_blk_sums             r_blk;
    t_tail_status          w_status;
    logic [1:0]            w_reg_idx;

    assign w_odd       = r_row[0];
    assign w_row_last  = (r_row == ROW_LAST);
    assign w_tail_busy = r_blk.valid || w_status.busy;
    assign o_in_stall  = w_status.hold && w_tail_busy;
    assign w_accept    = i_in_valid && !o_in_stall;

    // Column lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        tfmd_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (w_accept),
            .i_odd      (w_odd),
            .i_row_last (w_row_last),
            .i_old      (i_in_data.old_pixels[PIX_W*g +: PIX_W]),
            .i_new      (i_in_data.new_pixels[PIX_W*g +: PIX_W]),
            .o_abs_diff (w_abs[g]),
            .o_mag      (w_mag[g])
        );
    end

    // Row total of absolute differences
    always_comb begin
        w_row_sum = '0;
        for (int i = 0; i < LANES; i++) begin
            w_row_sum = w_row_sum + ROW_W'(w_abs[i]);
        end
    end

    // Advance the row counter and the even/odd sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_even <= '0;
            r_odd  <= '0;
        end else if (w_accept) begin
            r_row <= r_row + 1'b1;
            if (w_row_last) begin
                r_even <= '0;
                r_odd  <= '0;
            end else if (w_odd) begin
                r_odd <= r_odd + REL_W'(w_row_sum);
            end else begin
                r_even <= r_even + REL_W'(w_row_sum);
            end
        end
    end

    // Hand the finished block to the merge stages, hold while they hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk.valid <= 1'b0;
        end else if (w_accept && w_row_last) begin
            r_blk.valid <= 1'b1;
        end else if (!w_status.hold) begin
            r_blk.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_row_last) begin
            r_blk.last <= i_in_data.frame_last;
            r_blk.even <= r_even;
            r_blk.odd  <= r_odd + REL_W'(w_row_sum);
        end
    end

    tfmd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blk       (r_blk),
        .i_mag       (w_mag),
        .i_cfg       (r_cfg),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Configuration registers
    assign w_reg_idx = paddr[3:2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.combing_threshold   <= COMBING_RST;
            r_cfg.temporal_limit      <= TEMPORAL_RST;
            r_cfg.low_noise_threshold <= LOW_NOISE_RST;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg_idx)
                REG_COMBING:   r_cfg.combing_threshold   <= pwdata[CFG_W-1:0];
                REG_TEMPORAL:  r_cfg.temporal_limit      <= pwdata[CFG_W-1:0];
                REG_LOW_NOISE: r_cfg.low_noise_threshold <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_COMBING:   prdata = APB_DW'(r_cfg.combing_threshold);
            REG_TEMPORAL:  prdata = APB_DW'(r_cfg.temporal_limit);
            REG_LOW_NOISE: prdata = APB_DW'(r_cfg.low_noise_threshold);
            default:       prdata = '0;
        endcase
    end

endmodule

[rtl/core/tfmd_checker.sv]
// ============================================================================
// tfmd_checker
// Port-level checks on the telecine field metric decider.
// ============================================================================
`include "telecine_field_metric_decider_top_defines.svh"

module tfmd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input tfmd_pkg::t_out_item         o_out_data,
    input logic                        pready
);
    import tfmd_pkg::*;

    logic w_out_held;
    logic w_rel_ok;

    assign w_out_held = o_out_valid && i_out_stall;
    assign w_rel_ok   = (o_out_data.rel_even <= REL_LIMIT) &&
                        (o_out_data.rel_odd <= REL_LIMIT);

    // Register port never waits
    `TFMD_ASSERT_NOW(a_pready_high, pready, "pready low")

    // Input backs up only behind a stalled result
    `TFMD_ASSERT_IMP(a_in_stall_cause, o_in_stall, w_out_held, "input stalled, output free")

    // A stalled result stays
    `TFMD_ASSERT_NXT(a_out_held, w_out_held, o_out_valid, "result lost under stall")

    // Even and odd maxima stay within one block's range
    `TFMD_ASSERT_IMP(a_rel_bound, o_out_valid, w_rel_ok, "maximum out of range")

endmodule

bind telecine_field_metric_decider_top tfmd_checker u_tfmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .pready      (pready)
);
